>>> hw/rtl/icv_pkg.sv
// Package for the identity code validator: word token type, position constants,
// check symbol table and the small arithmetic helpers used by the front and back.
// No dependencies.
package icv_pkg;

    localparam int unsigned CODE_LEN    = 11;
    localparam int unsigned CENTURY_POS = 6;
    localparam int unsigned CHECK_POS   = 10;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned POS_W       = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_A     = 8'h41;

    localparam logic [1:0] CENT_NONE = 2'd0;
    localparam logic [1:0] CENT_1800 = 2'd1;
    localparam logic [1:0] CENT_1900 = 2'd2;
    localparam logic [1:0] CENT_2000 = 2'd3;

    localparam logic [7:0] CHECK_TABLE [31] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h48, 8'h4A, 8'h4B, 8'h4C,
        8'h4D, 8'h4E, 8'h50, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
        8'h59
    };

    // Role of a character, set by its place in the code.
    typedef enum logic [2:0] {
        KIND_DAY,
        KIND_MONTH,
        KIND_YEAR,
        KIND_CENTURY,
        KIND_SERIAL,
        KIND_CHECK,
        KIND_EXTRA
    } kind_t;

    // Classified character handed from the front to the back.
    // value holds the digit, the century code or the check symbol index.
    typedef struct packed {
        kind_t      kind;
        logic       sym_ok;
        logic [4:0] value;
        logic       last;
    } token_t;

    // Index of a character in the check symbol table; ok is low if absent.
    function automatic logic [5:0] check_index(input logic [7:0] c);
        logic [5:0] res;
        res = 6'd0;
        for (int i = 0; i < 31; i++) begin
            if (c == CHECK_TABLE[i]) begin
                res = {1'b1, 5'(i)};
            end
        end
        return res;
    endfunction

    // Remainder by 31 of a value below 496.
    function automatic logic [4:0] mod31(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (r >= 9'd248) r = r - 9'd248;
        if (r >= 9'd124) r = r - 9'd124;
        if (r >= 9'd62)  r = r - 9'd62;
        if (r >= 9'd31)  r = r - 9'd31;
        return r[4:0];
    endfunction

    // Days in a month numbered 1 to 12.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/icv_channel_if.sv
// Handshake channels of the identity code validator: the character word channel
// and the result word channel. No dependencies.
interface icv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface icv_result_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

>>> hw/rtl/icv_front.sv
// Front of the identity code validator: tracks the character position and turns
// each accepted word into a classified token. Depends on icv_pkg.
module icv_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      char_code,
    input  logic            is_last,
    input  logic            push_ok,
    output logic            push,
    output icv_pkg::token_t token
);

    logic [icv_pkg::POS_W-1:0] pos_reg;
    logic [icv_pkg::POS_W-1:0] pos_next;
    logic [5:0]                chk;

    assign push = in_valid && push_ok;
    assign chk  = icv_pkg::check_index(char_code);

    always_comb
    begin
        token.last   = is_last;
        token.sym_ok = (char_code >= icv_pkg::CHAR_ZERO) && (char_code <= icv_pkg::CHAR_NINE);
        token.value  = {1'b0, char_code[3:0]};
        if (pos_reg < icv_pkg::POS_W'(2)) begin
            token.kind = icv_pkg::KIND_DAY;
        end else if (pos_reg < icv_pkg::POS_W'(4)) begin
            token.kind = icv_pkg::KIND_MONTH;
        end else if (pos_reg < icv_pkg::POS_W'(icv_pkg::CENTURY_POS)) begin
            token.kind = icv_pkg::KIND_YEAR;
        end else if (pos_reg == icv_pkg::POS_W'(icv_pkg::CENTURY_POS)) begin
            token.kind   = icv_pkg::KIND_CENTURY;
            token.sym_ok = 1'b1;
            priority if (char_code == icv_pkg::CHAR_PLUS) begin
                token.value = {3'b0, icv_pkg::CENT_1800};
            end else if (char_code == icv_pkg::CHAR_MINUS) begin
                token.value = {3'b0, icv_pkg::CENT_1900};
            end else if (char_code == icv_pkg::CHAR_A) begin
                token.value = {3'b0, icv_pkg::CENT_2000};
            end else begin
                token.value  = {3'b0, icv_pkg::CENT_NONE};
                token.sym_ok = 1'b0;
            end
        end else if (pos_reg < icv_pkg::POS_W'(icv_pkg::CHECK_POS)) begin
            token.kind = icv_pkg::KIND_SERIAL;
        end else if (pos_reg == icv_pkg::POS_W'(icv_pkg::CHECK_POS)) begin
            token.kind   = icv_pkg::KIND_CHECK;
            token.sym_ok = chk[5];
            token.value  = chk[4:0];
        end else begin
            token.kind = icv_pkg::KIND_EXTRA;
        end
    end

    // The position saturates at the code length and restarts after the last word.
    always_comb
    begin
        pos_next = pos_reg;
        if (push) begin
            if (is_last) begin
                pos_next = '0;
            end else if (pos_reg < icv_pkg::POS_W'(icv_pkg::CODE_LEN)) begin
                pos_next = pos_reg + icv_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> hw/rtl/icv_queue.sv
// Short token queue between the front and the back of the identity code
// validator. Depends on icv_pkg.
module icv_queue #(
    parameter int unsigned DEPTH = icv_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  icv_pkg::token_t push_data,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output icv_pkg::token_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    icv_pkg::token_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = count_reg != CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/icv_back.sv
// Back of the identity code validator: applies tokens to the check remainder,
// date fields and error flag, and holds the result word. Depends on icv_pkg.
module icv_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    input  icv_pkg::token_t tok,
    output logic            pop,
    output logic            out_valid,
    output logic            out_res,
    input  logic            out_ready
);

    logic [4:0] residue_reg, residue_next;
    logic [6:0] day_reg, day_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] year_reg, year_next;
    logic [1:0] century_reg, century_next;
    logic       bad_reg, bad_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_res_reg, out_res_next;
    logic       leap;
    logic       date_ok;
    logic [6:0] digit7;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // A last token needs the result register free or draining.
    assign pop = tok_valid && (!tok.last || !out_valid_reg || out_ready);

    assign digit7   = 7'(tok.value[3:0]);

    // Only 2000 is a leap century; other years follow the rule of four.
    assign leap    = (year_reg[1:0] == 2'b00)
                  && ((year_reg != 7'd0) || (century_reg == icv_pkg::CENT_2000));
    assign date_ok = (century_reg != icv_pkg::CENT_NONE)
                  && (month_reg >= 7'd1) && (month_reg <= 7'd12)
                  && (day_reg >= 7'd1)
                  && (day_reg <= 7'(icv_pkg::month_len(month_reg[3:0], leap)));

    always_comb
    begin
        residue_next   = residue_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        century_next   = century_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        if (pop) begin
            unique case (tok.kind)
                icv_pkg::KIND_DAY, icv_pkg::KIND_MONTH,
                icv_pkg::KIND_YEAR, icv_pkg::KIND_SERIAL:
                begin
                    if (!tok.sym_ok) begin
                        bad_next = 1'b1;
                    end else begin
                        residue_next = icv_pkg::mod31(9'(residue_reg * 9'd10)
                                                      + 9'(tok.value[3:0]));
                        if (tok.kind == icv_pkg::KIND_DAY) begin
                            day_next = 7'(day_reg * 7'd10) + digit7;
                        end
                        if (tok.kind == icv_pkg::KIND_MONTH) begin
                            month_next = 7'(month_reg * 7'd10) + digit7;
                        end
                        if (tok.kind == icv_pkg::KIND_YEAR) begin
                            year_next = 7'(year_reg * 7'd10) + digit7;
                        end
                    end
                end
                icv_pkg::KIND_CENTURY:
                begin
                    if (!tok.sym_ok) begin
                        bad_next = 1'b1;
                    end else begin
                        century_next = tok.value[1:0];
                    end
                end
                icv_pkg::KIND_CHECK:
                begin
                    if (!tok.sym_ok || (tok.value != residue_reg)) begin
                        bad_next = 1'b1;
                    end
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase
            if (tok.last) begin
                // The date fields never change on the check character, so the
                // held values are the final ones.
                out_valid_next = 1'b1;
                out_res_next   = !bad_next && (tok.kind == icv_pkg::KIND_CHECK) && date_ok;
                residue_next   = '0;
                day_next       = '0;
                month_next     = '0;
                year_next      = '0;
                century_next   = icv_pkg::CENT_NONE;
                bad_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            residue_reg   <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            century_reg   <= icv_pkg::CENT_NONE;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            residue_reg   <= residue_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            century_reg   <= century_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/identity_code_validator_unit.sv
// Top level of the identity code validator: front classifier, token queue and
// back evaluator. Depends on icv_pkg, icv_channel_if, icv_front, icv_queue, icv_back.
//
// Usage: the identity code enters one ASCII character per word on the char channel,
// with is_last set on the word that ends the code. Every word without is_last gives
// no result; a word with is_last gives exactly one result word on the result channel,
// valid_res = 1 when the code has exactly eleven characters, every digit position
// holds a digit, the century sign is known, the date exists in the Gregorian calendar
// and the check character matches the remainder by 31 of the nine digits.
// Throughput is one character word per cycle while the token queue is not full. The
// result word for an accepted last word passes through the token queue and then
// the result register.
// When the receiver stalls, the result word is held in the result register; the next
// last token waits in the queue with later tokens behind it. The char channel drops
// ready only once the queue is full, so input words still flow while one result waits.
// Reset clears the position, all code fields, the queue and the result valid flag;
// the block is ready for a new code as soon as reset is released.
module identity_code_validator_unit #(
    parameter int unsigned QUEUE_DEPTH = icv_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    icv_char_if.sink     in_ch,
    icv_result_if.source out_ch
);

    icv_pkg::token_t front_token;
    icv_pkg::token_t back_token;
    logic            push;
    logic            queue_not_full;
    logic            queue_not_empty;
    logic            pop;

    assign in_ch.ready = queue_not_full;

    // Front: position tracking and character classification.
    icv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .char_code (in_ch.char_code),
        .is_last   (in_ch.is_last),
        .push_ok   (queue_not_full),
        .push      (push),
        .token     (front_token)
    );

    // Queue: lets the front keep taking words while the back waits on the receiver.
    icv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_token),
        .not_full  (queue_not_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (back_token)
    );

    // Back: remainder, date and error tracking, and the result register.
    icv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (queue_not_empty),
        .tok       (back_token),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_res   (out_ch.valid_res),
        .out_ready (out_ch.ready)
    );

endmodule

>>> bench/identity_code_validator_unit_tb.sv
// Self-checking bench for identity_code_validator_unit: streams identity code words,
// predicts each verdict and compares every result word in order.
// Depends on icv_pkg, icv_channel_if and the validator RTL.
module identity_code_validator_unit_tb;

    // Idle margin given to the block after every owed verdict has arrived.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Far above the slowest legal run of about 1300 words with both sides stalling.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_STALL = 150;

    // Check symbols in order of the remainder by 31; symbol 0 is the leftmost byte.
    localparam logic [8*31-1:0] CHECK_SYMBOLS = "0123456789ABCDEFHJKLMNPRSTUVWXY";

    logic clk = 1'b0;
    logic rst_n;

    icv_char_if   char_ch ();
    icv_result_if result_ch ();

    identity_code_validator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (char_ch),
        .out_ch (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted state of the code being received.
    logic [3:0] code_pos;
    logic [4:0] code_residue;
    logic [6:0] code_day;
    logic [6:0] code_month;
    logic [6:0] code_year;
    logic [1:0] code_century;
    logic       code_bad;

    // Verdicts still owed by the block, oldest first.
    logic expected_verdicts[$];
    // Characters of the next code to send.
    logic [7:0] code_buf[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned words_sent = 0;
    int unsigned codes_seen = 0;
    int unsigned verdicts_checked = 0;
    int unsigned codes_accepted = 0;
    int unsigned failures = 0;

    function automatic logic [7:0] symbol_at(input int unsigned idx);
        return CHECK_SYMBOLS[8*(30 - idx) +: 8];
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            2:          return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic bit date_is_real();
        int unsigned year;
        bit leap;
        case (code_century)
            icv_pkg::CENT_1800: year = 1800;
            icv_pkg::CENT_1900: year = 1900;
            icv_pkg::CENT_2000: year = 2000;
            default:            return 1'b0;
        endcase
        year = year + code_year;
        if (code_month < 1 || code_month > 12)
        begin
            return 1'b0;
        end
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        return code_day >= 1 && code_day <= days_in_month(code_month, leap);
    endfunction

    function automatic void clear_code();
        code_pos     = '0;
        code_residue = '0;
        code_day     = '0;
        code_month   = '0;
        code_year    = '0;
        code_century = icv_pkg::CENT_NONE;
        code_bad     = 1'b0;
    endfunction

    // Advances the predicted state by one accepted word. A word with is_last queues
    // the verdict: the code must be exactly eleven characters and flawless.
    function automatic void absorb_char(input logic [7:0] c, input logic last);
        int unsigned digit;
        bit at_check;
        at_check = (code_pos == icv_pkg::CHECK_POS);
        if (code_pos < icv_pkg::CODE_LEN)
        begin
            if (code_pos == icv_pkg::CENTURY_POS)
            begin
                case (c)
                    icv_pkg::CHAR_PLUS:  code_century = icv_pkg::CENT_1800;
                    icv_pkg::CHAR_MINUS: code_century = icv_pkg::CENT_1900;
                    icv_pkg::CHAR_A:     code_century = icv_pkg::CENT_2000;
                    default:             code_bad = 1'b1;
                endcase
            end
            else if (code_pos == icv_pkg::CHECK_POS)
            begin
                if (c != symbol_at(code_residue))
                begin
                    code_bad = 1'b1;
                end
            end
            else if (c < icv_pkg::CHAR_ZERO || c > icv_pkg::CHAR_NINE)
            begin
                code_bad = 1'b1;
            end
            else
            begin
                digit = c - icv_pkg::CHAR_ZERO;
                code_residue = 5'((code_residue * 10 + digit) % 31);
                if (code_pos < 2)
                begin
                    code_day = 7'(code_day * 10 + digit);
                end
                else if (code_pos < 4)
                begin
                    code_month = 7'(code_month * 10 + digit);
                end
                else if (code_pos < 6)
                begin
                    code_year = 7'(code_year * 10 + digit);
                end
            end
            code_pos = code_pos + 4'd1;
        end
        else
        begin
            // Any word beyond the eleventh spoils the code.
            code_bad = 1'b1;
        end
        if (last)
        begin
            expected_verdicts.push_back(!code_bad && at_check && date_is_real());
            codes_seen++;
            clear_code();
        end
    endfunction

    // Both handshakes are observed at the rising edge, input first, so a verdict is
    // always queued before the block could possibly return it.
    always @(posedge clk)
    begin : observe
        logic want;
        if (rst_n)
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                absorb_char(char_ch.char_code, char_ch.is_last);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result word, expected none, actual %0b",
                             $time, result_ch.valid_res);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (want)
                    begin
                        codes_accepted++;
                    end
                    if (result_ch.valid_res !== want)
                    begin
                        failures++;
                        $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                                 $time, want, result_ch.valid_res);
                    end
                end
            end
        end
    end

    // Receiver: a long hold-off when one is requested, otherwise random stalls.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            result_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles with %0d verdicts outstanding",
                     $time, CYCLE_LIMIT, expected_verdicts.size());
            $display("status: fail");
            $finish;
        end
    end

    // Sends one word; called and returns at a falling edge. Idle cycles carry
    // random junk on the payload so that only valid qualifies it.
    task automatic send_word(input logic [7:0] c, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            char_ch.valid     = 1'b0;
            char_ch.char_code = 8'($urandom);
            char_ch.is_last   = 1'($urandom);
            @(negedge clk);
        end
        char_ch.valid     = 1'b1;
        char_ch.char_code = c;
        char_ch.is_last   = last;
        @(posedge clk);
        while (!char_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        char_ch.valid = 1'b0;
        words_sent++;
    endtask

    task automatic send_code_buf();
        for (int i = 0; i < code_buf.size(); i++)
        begin
            send_word(code_buf[i], i == code_buf.size() - 1);
        end
        code_buf.delete();
    endtask

    function automatic void push_digits(input int unsigned v, input int unsigned n);
        int unsigned div;
        div = 1;
        repeat (n - 1) div = div * 10;
        repeat (n)
        begin
            code_buf.push_back(icv_pkg::CHAR_ZERO + 8'((v / div) % 10));
            div = div / 10;
        end
    endfunction

    // Builds DDMMYY, sign, serial and a check symbol taken from the whole
    // nine-digit number, or a deliberately wrong symbol.
    function automatic void build_code(input int unsigned day, input int unsigned month,
                                       input int unsigned year, input logic [7:0] sign,
                                       input int unsigned serial, input bit good_check);
        int unsigned idx;
        code_buf.delete();
        push_digits(day, 2);
        push_digits(month, 2);
        push_digits(year, 2);
        code_buf.push_back(sign);
        push_digits(serial, 3);
        idx = (day * 10000000 + month * 100000 + year * 1000 + serial) % 31;
        if (!good_check)
        begin
            idx = (idx + $urandom_range(30, 1)) % 31;
        end
        code_buf.push_back(symbol_at(idx));
    endfunction

    // Mostly plausible dates, with February edges around the century leap rules
    // and a share of impossible day and month numbers.
    function automatic void build_random_code();
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned pick;
        logic [7:0] sign;
        pick = $urandom_range(9, 0);
        year = $urandom_range(99, 0);
        if (pick < 6)
        begin
            month = $urandom_range(12, 1);
            day   = $urandom_range(31, 1);
        end
        else if (pick < 8)
        begin
            month = 2;
            day   = $urandom_range(30, 28);
            case ($urandom_range(2, 0))
                0:       year = 0;
                1:       year = 4 * $urandom_range(24, 0);
                default: ;
            endcase
        end
        else
        begin
            month = $urandom_range(99, 0);
            day   = $urandom_range(99, 0);
        end
        case ($urandom_range(2, 0))
            0:       sign = icv_pkg::CHAR_PLUS;
            1:       sign = icv_pkg::CHAR_MINUS;
            default: sign = icv_pkg::CHAR_A;
        endcase
        build_code(day, month, year, sign, $urandom_range(999, 0), $urandom_range(9, 0) != 0);
    endfunction

    // Lets every owed verdict arrive, then gives the block a few idle cycles.
    task automatic wait_all_results();
        while (expected_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // 29 February 2000 exists because 2000 is divisible by 400.
    task automatic test_leap_day();
        build_code(29, 2, 0, icv_pkg::CHAR_A, 58, 1'b1);
        send_code_buf();
    endtask

    // A lone NUL with the last mark is both too short and a non-digit.
    task automatic test_short_nul();
        code_buf.push_back(8'h00);
        send_code_buf();
    endtask

    // A correct eleven-character code followed by an all-ones word is too long.
    task automatic test_too_long();
        build_code(31, 12, 99, icv_pkg::CHAR_PLUS, 999, 1'b1);
        code_buf.push_back(8'hFF);
        send_code_buf();
    endtask

    // Most codes are well formed with random content so that the date and check
    // logic is reached; the rest carry a bad character, are cut short, run long
    // or are pure noise.
    task automatic test_random_traffic(input int unsigned n_words,
                                       input int unsigned send_idle,
                                       input int unsigned recv_idle);
        int unsigned first;
        int unsigned kind;
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        first = words_sent;
        while (words_sent - first < n_words)
        begin
            build_random_code();
            kind = $urandom_range(99, 0);
            if (kind >= 93)
            begin
                code_buf.delete();
                repeat ($urandom_range(14, 1)) code_buf.push_back(8'($urandom));
            end
            else if (kind >= 87)
            begin
                repeat ($urandom_range(3, 1)) code_buf.push_back(8'($urandom));
            end
            else if (kind >= 80)
            begin
                repeat ($urandom_range(10, 1)) void'(code_buf.pop_back());
            end
            else if (kind >= 70)
            begin
                code_buf[$urandom_range(10, 0)] = 8'($urandom);
            end
            send_code_buf();
        end
    endtask

    // The receiver holds off while codes keep coming at full rate, so the token
    // queue fills and the char channel must drop ready until the stall ends.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = LONG_STALL;
        repeat (4)
        begin
            build_random_code();
            send_code_buf();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.char_code = '0;
        char_ch.is_last = 1'b0;
        result_ch.ready = 1'b0;
        clear_code();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_leap_day();
        test_short_nul();
        test_too_long();
        wait_all_results();

        test_random_traffic(430, 36, 55);
        test_backpressure();
        // The sender pauses here until the block has answered everything.
        wait_all_results();
        test_random_traffic(430, 55, 36);
        wait_all_results();
        test_random_traffic(430, 0, 0);
        wait_all_results();

        $display("Run covered %0d words in %0d codes; %0d verdicts checked, %0d codes valid.",
                 words_sent, codes_seen, verdicts_checked, codes_accepted);
        $display("Stalls on both sides, a %0d-cycle receiver hold-off and full-rate streams.",
                 LONG_STALL);
        if (failures == 0 && expected_verdicts.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
